/* sv/srac_pkg.sv */
// Package for the send rate adaptation controller.
// Holds constants, op codes and the sequencer state type; no dependencies.
`timescale 1ns / 1ps
package srac_pkg;
  localparam int unsigned PivotDepthDef  = 5;
  localparam int unsigned GrowthDepthDef = 3;
  localparam int unsigned RateW   = 40;
  localparam int unsigned BufW    = 31;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DivW    = 60;  // bytes * 1e6 fits in 60 bits
  localparam logic [7:0] SettleRst  = 8'd30;
  localparam logic [7:0] SpacingRst = 8'd10;
  localparam logic [19:0] UsPerSec  = 20'd1000000;
  localparam logic [RateW-1:0] RateMax = {RateW{1'b1}};

  typedef enum logic [1:0] {
    OpSent    = 2'd0,
    OpBuffer  = 2'd1,
    OpTick    = 2'd2,
    OpDiscard = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CfgSettle  = 1'b0,
    CfgSpacing = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    StIdle, StMul, StDiv, StDecide, StPush, StSum, StAvg, StOut
  } state_e;

  localparam logic [1:0] DirHold = 2'b00;
  localparam logic [1:0] DirUp   = 2'b01;
  localparam logic [1:0] DirDown = 2'b11;
endpackage

/* sv/send_rate_adaptation_controller_core.sv */
// Send rate adaptation controller: samples accumulate one per cycle while idle
// with no result pending; a tick runs a bit-serial multiply by 1e6, a bit-serial
// divide, a one-entry-per-cycle pivot sum and a serial divide for the average;
// the result register then waits for tready.
// Reset (rst_ni low, asynchronous) clears all control state and restores
// the holdoff registers to 30 s and 10 s.
`timescale 1ns / 1ps
module send_rate_adaptation_controller_core
  import srac_pkg::*;
#(
  parameter int unsigned PIVOT_DEPTH  = PivotDepthDef,
  parameter int unsigned GROWTH_DEPTH = GrowthDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: bytes_sent[31:0], buffer_size[62:32], elapsed_us[94:63], now_sec[126:95], pad
  input  logic [127:0] s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: pivot_avg[39:0], measured_rate[79:40], pad
  output logic [79:0]  m_axis_tdata,
  // tuser: direction[1:0]
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i
);
  localparam int unsigned PcW  = $clog2(PIVOT_DEPTH + 1);
  localparam int unsigned PiW  = (PIVOT_DEPTH > 1) ? $clog2(PIVOT_DEPTH) : 1;
  localparam int unsigned GcW  = $clog2(GROWTH_DEPTH + 1);
  localparam int unsigned SumW = RateW + PcW;
  // The marker bit reaches the top once all multiplier bits are consumed.
  localparam logic [20:0] MulDone = {1'b1, 20'd0};

  logic [1:0]       op;
  logic [31:0]      in_bytes, in_elapsed, in_now;
  logic [BufW-1:0]  in_buf;
  assign op         = s_axis_tuser;
  assign in_bytes   = s_axis_tdata[31:0];
  assign in_buf     = s_axis_tdata[62:32];
  assign in_elapsed = s_axis_tdata[94:63];
  assign in_now     = s_axis_tdata[126:95];

  state_e state_q, state_d;
  logic [7:0] settle_q, spacing_q;
  logic [RateW-1:0] sent_q;
  logic buf_seen_q, had_dec_q, inc_seen_q, out_v_q;
  logic [BufW-1:0] buf_latest_q;
  logic [BufW-1:0] growth_q [GROWTH_DEPTH];
  logic [GcW-1:0] gcnt_q;
  logic [TimeW-1:0] last_dec_q, last_inc_q, now_q, elap_q;
  logic [1:0] prev_dir_q, dir_q;
  logic [RateW-1:0] pivot_q [PIVOT_DEPTH];
  logic [PcW-1:0] pcnt_q, sidx_q;
  logic [SumW-1:0] sum_q;
  logic [DivW-1:0] prod_q;
  logic [20:0] mul_q;
  logic [RateW-1:0] rate_q, avg_q, out_avg_q, out_rate_q;
  logic [1:0] out_dir_q;
  logic tick_busy;

  // Divider shared between rate and pivot average.
  logic div_start, div_done;
  logic [DivW-1:0] div_num, div_quo;
  logic [TimeW-1:0] div_den;
  srac_serdiv #(.NumW(DivW), .DenW(TimeW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign tick_busy     = (state_q != StIdle);
  assign s_axis_tready = !tick_busy && !out_v_q;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_rate_q, out_avg_q};
  assign m_axis_tuser  = out_dir_q;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // Trend over the growth history, newest at index 0.
  logic signed [GcW+1:0] trend;
  always_comb begin
    trend = '0;
    for (int i = 0; i < GROWTH_DEPTH; i++) begin
      if (GcW'(i) < gcnt_q) begin
        if (i == 0) begin
          if (growth_q[0] != '0) trend = trend - 2'sd1;
        end else if (growth_q[i] > growth_q[i-1]) trend = trend - 2'sd1;
        else if (growth_q[i] < growth_q[i-1]) trend = trend + 2'sd1;
      end
    end
  end

  logic settled, spaced;
  logic [TimeW-1:0] dt_dec, dt_inc;
  assign dt_dec  = now_q - last_dec_q;
  assign dt_inc  = now_q - last_inc_q;
  assign settled = dt_dec > {24'd0, settle_q};
  assign spaced  = !inc_seen_q || (dt_inc > {24'd0, spacing_q});

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = prod_q;
    div_den   = elap_q;
    unique case (state_q)
      StIdle:   if (acc && op == OpTick) state_d = StMul;
      StMul:    if (mul_q == MulDone) begin
        state_d = (elap_q == '0) ? StDecide : StDiv;
        div_start = (elap_q != '0);
      end
      StDiv:    if (div_done) state_d = StDecide;
      StDecide: state_d = StPush;
      StPush:   state_d = StSum;
      StSum:    if (sidx_q == pcnt_q) begin
        state_d = (pcnt_q == '0) ? StOut : StAvg;
        div_start = (pcnt_q != '0);
        div_num = DivW'(sum_q);
        div_den = TimeW'(pcnt_q);
      end
      StAvg:    if (div_done) state_d = StOut;
      StOut:    state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; settle_q <= SettleRst; spacing_q <= SpacingRst;
      sent_q <= '0; buf_seen_q <= 1'b0; buf_latest_q <= '0; gcnt_q <= '0;
      had_dec_q <= 1'b0; last_dec_q <= '0; inc_seen_q <= 1'b0;
      last_inc_q <= '0; prev_dir_q <= DirHold; pcnt_q <= '0; out_v_q <= 1'b0;
      dir_q <= DirHold;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgSettle:  settle_q  <= cfg_data_i;
          CfgSpacing: spacing_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      if (acc) begin
        unique case (op)
          OpSent: begin
            if ({1'b0, sent_q} + (RateW+1)'(in_bytes) > {1'b0, RateMax})
              sent_q <= RateMax;
            else sent_q <= sent_q + RateW'(in_bytes);
          end
          OpBuffer: begin buf_latest_q <= in_buf; buf_seen_q <= 1'b1; end
          OpDiscard: buf_seen_q <= 1'b0;
          default: begin
            if (buf_seen_q && gcnt_q != GcW'(GROWTH_DEPTH)) gcnt_q <= gcnt_q + 1'b1;
          end
        endcase
      end
      if (state_q == StDecide) begin
        dir_q <= DirHold;
        if (buf_seen_q) begin
          if (trend <= 0 && (!had_dec_q || (settled && spaced))) begin
            dir_q <= DirUp;
          end else if (trend > 0) begin
            dir_q <= DirDown; had_dec_q <= 1'b1; last_dec_q <= now_q;
          end
        end
      end
      if (state_q == StPush && buf_seen_q) begin
        if (prev_dir_q == DirDown && dir_q != DirDown && pcnt_q != PcW'(PIVOT_DEPTH))
          pcnt_q <= pcnt_q + 1'b1;
      end
      if (state_q == StOut) begin
        if (buf_seen_q) begin
          if (rate_q > avg_q && pcnt_q != PcW'(PIVOT_DEPTH)) pcnt_q <= pcnt_q + 1'b1;
          prev_dir_q <= dir_q;
          if (dir_q == DirUp) begin last_inc_q <= now_q; inc_seen_q <= 1'b1; end
        end
        out_v_q <= 1'b1;
        sent_q <= '0;
        buf_seen_q <= 1'b0;
      end
    end
  end

  // Payload path: growth shift, bit-serial multiply, rate and average capture, pivot ring and sum, output registers.
  always_ff @(posedge clk_i) begin
    if (acc && op == OpTick) begin
      elap_q <= in_elapsed; now_q <= in_now;
      prod_q <= '0; mul_q <= {UsPerSec, 1'b1};
      if (buf_seen_q) begin
        growth_q[0] <= buf_latest_q;
        for (int i = 1; i < GROWTH_DEPTH; i++) growth_q[i] <= growth_q[i-1];
      end
    end
    if (state_q == StMul && mul_q != MulDone) begin
      // Shift-add on the multiplier bits, MSB first.
      prod_q <= (prod_q << 1) + (mul_q[20] ? DivW'(sent_q) : '0);
      mul_q  <= {mul_q[19:0], 1'b0};
    end
    if (state_q == StMul && mul_q == MulDone && elap_q == '0) rate_q <= RateMax;
    if (state_q == StDiv && div_done)
      rate_q <= (div_quo[DivW-1:RateW] != '0) ? RateMax : div_quo[RateW-1:0];
    if (state_q == StPush) begin
      sum_q <= '0; sidx_q <= '0; avg_q <= '0;
      if (buf_seen_q && prev_dir_q == DirDown && dir_q != DirDown) begin
        pivot_q[0] <= rate_q;
        for (int i = 1; i < PIVOT_DEPTH; i++) pivot_q[i] <= pivot_q[i-1];
      end
    end
    if (state_q == StSum && sidx_q != pcnt_q) begin
      sum_q  <= sum_q + SumW'(pivot_q[sidx_q[PiW-1:0]]);
      sidx_q <= sidx_q + 1'b1;
    end
    if (state_q == StAvg && div_done) avg_q <= div_quo[RateW-1:0];
    if (state_q == StOut) begin
      out_dir_q  <= dir_q;
      out_avg_q  <= buf_seen_q ? avg_q : '0;
      out_rate_q <= rate_q;
      if (buf_seen_q && rate_q > avg_q) begin
        pivot_q[0] <= rate_q;
        for (int i = 1; i < PIVOT_DEPTH; i++) pivot_q[i] <= pivot_q[i-1];
      end
    end
  end
endmodule

/* sv/srac_serdiv.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on srac_pkg for widths.
`timescale 1ns / 1ps
module srac_serdiv
  import srac_pkg::*;
#(
  parameter int unsigned NumW = DivW,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  assign trial  = {rem_q, quo_q[NumW-1]};
  assign done_o = busy_q && (cnt_q == CntW'(1)) ? 1'b1 : 1'b0;
  assign quo_o  = quo_d;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DenW'(trial - {1'b0, den_q});
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end
endmodule

/* sv/srac_checker.sv */
// Port-level checker for the send rate adaptation controller.
// Depends on srac_pkg; bound to the top level below.
`timescale 1ns / 1ps
module srac_checker
  import srac_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  a_dir_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'b10) else $error("bad direction");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_tick_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OpTick |=> !s_axis_tready)
    else $error("ready during tick");
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
endmodule

bind send_rate_adaptation_controller_core srac_checker u_srac_checker (.*);
